FILE: rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

    // field widths
    localparam int ADDR_W = 20;
    localparam int LINE_W = 8;
    localparam int COL_W  = 7;
    localparam int CELL_W = 15;
    localparam int VAL_W  = 16;
    localparam int CNT_W  = 4;

    // parameter defaults
    localparam int COLUMNS_DEF   = 80;
    localparam int ROWS_DEF      = 25;
    localparam int TAB_WIDTH_DEF = 8;
    localparam int CONSOLES_DEF  = 4;

    // register reset values
    localparam logic [ADDR_W-1:0] BASE_RESET = 20'hA0000;
    localparam logic [7:0]        ATTR_RESET = 8'h07;

    // register indexes
    localparam logic REG_BASE = 1'b0;
    localparam logic REG_ATTR = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_CELL   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_CURSOR = 2'd2;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // pending operation of the sequencer
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_CELL   = 2'd1;
    localparam logic [1:0] OP_SCROLL = 2'd2;
    localparam logic [1:0] OP_CURSOR = 2'd3;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
    } pos_t;

    typedef struct packed {
        logic en;
        pos_t pos;
    } pos_wr_t;

endpackage

FILE: rtl/core/tcw_pos_store.sv
`timescale 1ns / 1ps

// Line and column of each console; one read and one write port.
module tcw_pos_store #(
    parameter int CONSOLES = tcw_pkg::CONSOLES_DEF,
    parameter int CON_W    = (CONSOLES > 1) ? $clog2(CONSOLES) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CON_W-1:0] rd_idx,
    output tcw_pkg::pos_t    rd_pos,
    input  logic [CON_W-1:0] wr_idx,
    input  tcw_pkg::pos_wr_t wr
);

    tcw_pkg::pos_t pos_reg [CONSOLES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CONSOLES; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            pos_reg[wr_idx] <= wr.pos;
        end
    end

    assign rd_pos = pos_reg[rd_idx];

endmodule

FILE: rtl/core/text_console_cell_writer_top.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid/s_tready    tdata: character; tuser: console_index; tlast: end_of_buffer
// m_*      out  m_tvalid/m_tready    tdata: address, value; tuser: kind; tlast: last
// cfg_*    in   cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
// A request is accepted while the sequencer is idle; each result then passes
// the shared multiplier (line * COLUMNS) and then loads the output register.
// A printable character writes one cell, a tab up to eight spaces, display start
// and cursor; a request that causes nothing leaves the sequencer idle. The input
// is ready only while the sequencer is idle, and a stalled output register holds
// it. Reset puts every console at line 0, column 0 and the registers at their defaults.
module text_console_cell_writer_top #(
    parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS      = tcw_pkg::ROWS_DEF,
    parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF,
    parameter int CONSOLES  = tcw_pkg::CONSOLES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic [1:0]  s_tuser,   // [1:0] console_index
    input  logic        s_tlast,   // end_of_buffer
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [19:0] address, [35:20] value, [39:36] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,   // last result of the character
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data
);

    localparam int CON_W = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [tcw_pkg::COL_W-1:0]  COL_LAST = tcw_pkg::COL_W'(COLUMNS - 1);
    localparam logic [tcw_pkg::LINE_W-1:0] ROW_LAST = tcw_pkg::LINE_W'(ROWS - 1);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [tcw_pkg::ADDR_W-1:0] base_reg;
    logic [7:0]                 attr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= tcw_pkg::BASE_RESET;
            attr_reg <= tcw_pkg::ATTR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tcw_pkg::REG_BASE: base_reg <= cfg_data;
                tcw_pkg::REG_ATTR: attr_reg <= cfg_data[7:0];
                default:           base_reg <= base_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // tab length table: spaces from a column to the next stop
    // ---------------------------------------------------------------
    logic [tcw_pkg::CNT_W-1:0] tab_len_tab [128];

    for (genvar g = 0; g < 128; g++)
    begin : g_tab
        assign tab_len_tab[g] = tcw_pkg::CNT_W'(TAB_WIDTH - (g % TAB_WIDTH));
    end

    // ---------------------------------------------------------------
    // per-console position store
    // ---------------------------------------------------------------
    logic [CON_W-1:0]  rd_idx;
    tcw_pkg::pos_t     rd_pos;
    logic [CON_W-1:0]  wr_idx;
    tcw_pkg::pos_wr_t  pos_wr;

    tcw_pos_store #(
        .CONSOLES (CONSOLES),
        .CON_W    (CON_W)
    ) u_pos_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (rd_idx),
        .rd_pos (rd_pos),
        .wr_idx (wr_idx),
        .wr     (pos_wr)
    );

    assign rd_idx = CON_W'(s_tuser);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    logic [1:0]                 state_reg, state_next;
    logic [1:0]                 op_reg, op_next;
    logic [CON_W-1:0]           con_reg, con_next;
    logic [7:0]                 ch_reg, ch_next;
    logic                       eob_reg, eob_next;
    logic [tcw_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [tcw_pkg::LINE_W-1:0] line_reg, line_next;
    logic [tcw_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tcw_pkg::CELL_W-1:0] prod_reg, prod_next;

    logic                       m_valid_reg, m_valid_next;
    logic [1:0]                 m_kind_reg, m_kind_next;
    logic [tcw_pkg::ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic [tcw_pkg::VAL_W-1:0]  m_value_reg, m_value_next;
    logic                       m_last_reg, m_last_next;

    logic                       accept;
    logic                       in_range;
    logic                       slot_free;
    logic [tcw_pkg::LINE_W-1:0] mul_a;
    logic [tcw_pkg::CELL_W-1:0] cell_idx;
    logic [tcw_pkg::LINE_W-1:0] line_inc;
    logic [tcw_pkg::CNT_W-1:0]  cnt_dec;
    logic [1:0]                 tail_op;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_range  = (int'(s_tuser) < CONSOLES);
    assign slot_free = !m_valid_reg || m_tready;

    // shared unit: one multiply by COLUMNS, registered
    assign mul_a    = (op_reg == tcw_pkg::OP_SCROLL) ? (line_reg - ROW_LAST) : line_reg;
    assign prod_next = tcw_pkg::CELL_W'({7'd0, mul_a} * tcw_pkg::CELL_W'(COLUMNS));
    assign cell_idx  = prod_reg + tcw_pkg::CELL_W'(col_reg);

    // what follows the cells of a character: more cells, cursor or nothing
    function automatic logic [1:0] OP_TAIL(input logic more, input logic eob);
        logic [1:0] op;
        if (more)
        begin
            op = tcw_pkg::OP_CELL;
        end
        else if (eob)
        begin
            op = tcw_pkg::OP_CURSOR;
        end
        else
        begin
            op = tcw_pkg::OP_NONE;
        end
        return op;
    endfunction

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        con_next     = con_reg;
        ch_next      = ch_reg;
        eob_next     = eob_reg;
        cnt_next     = cnt_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = m_kind_reg;
        m_addr_next  = m_addr_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;
        pos_wr       = '0;
        wr_idx       = con_reg;
        line_inc     = '0;
        cnt_dec      = '0;
        tail_op      = OP_TAIL(1'b0, eob_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_range)
                begin
                    con_next  = rd_idx;
                    eob_next  = s_tlast;
                    line_next = rd_pos.line;
                    col_next  = rd_pos.col;
                    ch_next   = s_tdata;
                    cnt_next  = '0;
                    tail_op   = OP_TAIL(1'b0, s_tlast);
                    line_inc  = rd_pos.line + 1'b1;
                    priority if (s_tdata == tcw_pkg::CH_TAB)
                    begin
                        ch_next  = tcw_pkg::CH_SPACE;
                        cnt_next = tab_len_tab[rd_pos.col];
                        op_next  = tcw_pkg::OP_CELL;
                    end
                    else if (s_tdata == tcw_pkg::CH_LF)
                    begin
                        line_next      = line_inc;
                        col_next       = '0;
                        pos_wr.en      = 1'b1;
                        pos_wr.pos     = '{line: line_inc, col: '0};
                        wr_idx         = rd_idx;
                        op_next        = (line_inc >= ROW_LAST) ? tcw_pkg::OP_SCROLL : tail_op;
                    end
                    else if (s_tdata >= tcw_pkg::CH_SPACE && s_tdata != tcw_pkg::CH_DEL)
                    begin
                        cnt_next = tcw_pkg::CNT_W'(1);
                        op_next  = tcw_pkg::OP_CELL;
                    end
                    else
                    begin
                        op_next = tail_op;
                    end
                    state_next = (op_next == tcw_pkg::OP_NONE) ? ST_IDLE : ST_MUL;
                end
            end

            ST_MUL:
            begin
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    m_addr_next  = '0;
                    unique case (op_reg)
                        tcw_pkg::OP_CELL:
                        begin
                            m_kind_next  = tcw_pkg::KIND_CELL;
                            m_addr_next  = base_reg + tcw_pkg::ADDR_W'({cell_idx, 1'b0});
                            m_value_next = {attr_reg, ch_reg};
                            cnt_dec      = cnt_reg - 1'b1;
                            cnt_next     = cnt_dec;
                            tail_op      = OP_TAIL(cnt_dec != '0, eob_reg);
                            line_inc     = line_reg + 1'b1;
                            if (col_reg >= COL_LAST)
                            begin
                                col_next  = '0;
                                line_next = line_inc;
                                op_next   = (line_inc >= ROW_LAST) ? tcw_pkg::OP_SCROLL
                                                                   : tail_op;
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                                op_next  = tail_op;
                            end
                            pos_wr.en  = 1'b1;
                            pos_wr.pos = '{line: line_next, col: col_next};
                        end
                        tcw_pkg::OP_SCROLL:
                        begin
                            m_kind_next  = tcw_pkg::KIND_START;
                            m_value_next = tcw_pkg::VAL_W'(prod_reg);
                            op_next      = OP_TAIL(cnt_reg != '0, eob_reg);
                        end
                        tcw_pkg::OP_CURSOR:
                        begin
                            m_kind_next  = tcw_pkg::KIND_CURSOR;
                            m_value_next = tcw_pkg::VAL_W'(cell_idx);
                            op_next      = tcw_pkg::OP_NONE;
                        end
                        default:
                        begin
                            m_valid_next = m_valid_reg && !m_tready;
                            op_next      = tcw_pkg::OP_NONE;
                        end
                    endcase
                    m_last_next = (op_next == tcw_pkg::OP_NONE);
                    state_next  = (op_next == tcw_pkg::OP_NONE) ? ST_IDLE : ST_MUL;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= tcw_pkg::OP_NONE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        con_reg     <= con_next;
        ch_reg      <= ch_next;
        eob_reg     <= eob_next;
        cnt_reg     <= cnt_next;
        line_reg    <= line_next;
        col_reg     <= col_next;
        m_kind_reg  <= m_kind_next;
        m_addr_reg  <= m_addr_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_value_reg, m_addr_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule
